>>> hw/rtl/orl_pkg.sv
// Shared types and codes for the ordered run list.
package orl_pkg;

   typedef enum logic [2:0] {
      KIND_APPEND = 3'd0,
      KIND_PUSH   = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_POP    = 3'd3,
      KIND_QUERY  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] minutes;
      logic [7:0] station;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/orl_store.sv
// Entry memory: one write port, one read port with registered read data.
module orl_store #(
   parameter int MAX_ENTRIES = 16,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                 clock,
   input  orl_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]        wr_addr,
   input  orl_pkg::entry_type   wr_data,
   input  logic [AW-1:0]        rd_addr,
   output orl_pkg::entry_type   rd_data
);
   import orl_pkg::*;

   entry_type entry_mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/orl_ctrl.sv
// Operation sequencer: circular list pointers, scan and shift walks, result register.
module orl_ctrl #(
   parameter int MAX_ENTRIES = 16,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  orl_pkg::kind_type    req_kind,
   input  orl_pkg::entry_type   req_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output orl_pkg::entry_type   rsp_entry,
   output logic [4:0]           rsp_count,
   output orl_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]        mem_wr_addr,
   output orl_pkg::entry_type   mem_wr_data,
   output logic [AW-1:0]        mem_rd_addr,
   input  orl_pkg::entry_type   mem_rd_data
);
   import orl_pkg::*;

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] off_ff, off_in;
   kind_type      kind_ff, kind_in;
   entry_type     key_ff, key_in;
   logic          res_ok_ff, res_ok_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;

   logic            full, empty, hit, last_scan, shift_more, out_free;
   logic [CW-1:0]   off_next;
   logic [AW-1:0]   head_inc, head_dec;
   logic [CW+4:0]   count_ext;

   // physical slot of logical position off
   function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(off);
      if (sum >= (CW+1)'(MAX_ENTRIES)) begin
         sum = sum - (CW+1)'(MAX_ENTRIES);
      end
      return sum[AW-1:0];
   endfunction

   assign full       = (count_ff == CW'(MAX_ENTRIES));
   assign empty      = (count_ff == '0);
   assign hit        = (mem_rd_data.station == key_ff.station);
   assign off_next   = off_ff + CW'(1);
   assign last_scan  = (off_next == count_ff);
   assign shift_more = ((CW+1)'(off_ff) + (CW+1)'(2)) < (CW+1)'(count_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign head_inc   = (head_ff == AW'(MAX_ENTRIES - 1)) ? '0 : head_ff + AW'(1);
   assign head_dec   = (head_ff == '0) ? AW'(MAX_ENTRIES - 1) : head_ff - AW'(1);
   assign count_ext  = (CW+5)'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind) inside
                  KIND_POP:                state_in = empty ? ST_DONE : ST_POP_WAIT;
                  KIND_REMOVE, KIND_QUERY: state_in = empty ? ST_DONE : ST_SCAN_RD;
                  default:                 state_in = ST_DONE;
               endcase
            end
         end
         ST_POP_WAIT: state_in = ST_DONE;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (hit) begin
               state_in = (kind_ff == KIND_REMOVE && !last_scan) ? ST_SHIFT_RD : ST_DONE;
            end else begin
               state_in = last_scan ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = shift_more ? ST_SHIFT_RD : ST_DONE;
         ST_DONE:     state_in = out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      res_ok_in    = res_ok_ff;
      res_entry_in = res_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_count_in = rsp_count_ff;
      mem_ctl      = '0;
      mem_wr_addr  = wrap_idx(head_ff, off_ff);
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = wrap_idx(head_ff, off_ff);
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind;
               key_in       = req_entry;
               off_in       = '0;
               res_ok_in    = 1'b0;
               res_entry_in = '0;
               case (req_kind)
                  KIND_APPEND: begin
                     if (!full) begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = wrap_idx(head_ff, count_ff);
                        mem_wr_data   = req_entry;
                        count_in      = count_ff + CW'(1);
                        res_ok_in     = 1'b1;
                     end
                  end
                  KIND_PUSH: begin
                     if (!full) begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = head_dec;
                        mem_wr_data   = req_entry;
                        head_in       = head_dec;
                        count_in      = count_ff + CW'(1);
                        res_ok_in     = 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (!empty) begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = head_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP_WAIT: begin
            res_entry_in = mem_rd_data;
            res_ok_in    = 1'b1;
            head_in      = head_inc;
            count_in     = count_ff - CW'(1);
         end
         ST_SCAN_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = wrap_idx(head_ff, off_ff);
         end
         ST_SCAN_CMP: begin
            if (hit) begin
               res_ok_in = 1'b1;
               if (kind_ff == KIND_REMOVE && last_scan) begin
                  count_in = count_ff - CW'(1);
               end
            end else begin
               off_in = off_next;
            end
         end
         ST_SHIFT_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = wrap_idx(head_ff, off_next);
         end
         ST_SHIFT_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = wrap_idx(head_ff, off_ff);
            mem_wr_data   = mem_rd_data;
            off_in        = off_next;
            if (!shift_more) begin
               count_in = count_ff - CW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_entry_in = res_entry_ff;
               rsp_count_in = count_ext[4:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff       <= off_in;
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      res_ok_ff    <= res_ok_in;
      res_entry_ff <= res_entry_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_entry = rsp_entry_ff;
   assign rsp_count = rsp_count_ff;

endmodule

>>> hw/rtl/ordered_run_list.sv
// Top level of the ordered run list.
//
// Holds up to MAX_ENTRIES (station, minutes) entries in order. Each request
// on the req_ stream carries one operation (append, push front, remove by
// station, pop head, query station) and yields exactly one response on the
// rsp_ stream: success flag, popped entry (zero unless a pop succeeded) and
// the entry count after the operation.
// Entries sit in a circular buffer in one memory with registered reads, so
// append, push front and pop move only the head pointer or the count.
// Append and push front write the memory as the request is taken; pop reads
// the head entry, then captures it. Query and remove walk the memory one
// entry at a time (read, then compare), and a remove that hits then moves
// each later entry up one place (read, then write).
// One request is handled at a time; req_tready is high only while idle.
// A finished response waits in its output register while the next request
// is taken; a stalled receiver holds the block only once a second response
// is ready. Reset empties the list and drops any pending response; entry
// contents are not cleared.
module ordered_run_list #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // station[7:0], minutes[15:8]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_station[7:0], out_minutes[15:8], entry_count[20:16]
   output logic        rsp_tuser    // ok
);
   import orl_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   entry_type     req_entry, rsp_entry, mem_wr_data, mem_rd_data;
   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic          rsp_ok;
   logic [4:0]    rsp_count;

   assign req_entry.station = req_tdata[7:0];
   assign req_entry.minutes = req_tdata[15:8];

   orl_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (kind_type'(req_tuser)),
      .req_entry   (req_entry),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_ok      (rsp_ok),
      .rsp_entry   (rsp_entry),
      .rsp_count   (rsp_count),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   orl_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {3'b000, rsp_count, rsp_entry.minutes, rsp_entry.station};
   assign rsp_tuser = rsp_ok;

endmodule

>>> hw/rtl/orl_checker.sv
// Port-level checks for the ordered run list, bound to the top level.
module orl_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // reset drops any pending response
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // popped entry fields are zero on a failed request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'h0000)
      else $error("entry data on failed response");

   // count never exceeds the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_ENTRIES > 31) || (rsp_tdata[20:16] <= 5'(MAX_ENTRIES)))
      else $error("entry count above capacity");

endmodule

bind ordered_run_list orl_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_orl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/tb_top.sv
// Self-checking testbench for the ordered run list: directed and random list traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import orl_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic       ok;
      logic [7:0] station;
      logic [7:0] minutes;
      logic [4:0] entry_count;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // station[7:0], minutes[15:8]
   logic [2:0]  req_tuser = '0;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // out_station[7:0], out_minutes[15:8], entry_count[20:16]
   logic        rsp_tuser;        // ok

   entry_type       run_list[$];
   list_result_type due_results[$];

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit hold_off_req = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int err_count = 0;
   int n_req = 0;
   int n_rsp = 0;
   int n_pops = 0;
   int full_hits = 0;
   int empty_hits = 0;

   // cumulative cut points: append, push, remove, pop, query; the rest are spare kinds
   int kind_cuts [3][5] = '{'{35, 65, 75, 85, 97},
                            '{10, 18, 48, 83, 97},
                            '{22, 42, 62, 80, 97}};

   ordered_run_list #(.MAX_ENTRIES(LIST_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_left = HOLD_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic list_result_type apply_list_op(logic [2:0] kind, logic [7:0] st,
                                                      logic [7:0] mn);
      list_result_type r;
      entry_type       e;
      int              pos;
      r = '0;
      pos = -1;
      case (kind)
         KIND_APPEND, KIND_PUSH: begin
            if (run_list.size() < LIST_DEPTH) begin
               e.station = st;
               e.minutes = mn;
               if (kind == KIND_APPEND) run_list.push_back(e);
               else run_list.push_front(e);
               r.ok = 1'b1;
            end else begin
               full_hits++;
            end
         end
         KIND_REMOVE, KIND_QUERY: begin
            foreach (run_list[i]) begin
               if (pos < 0 && run_list[i].station == st) pos = i;
            end
            r.ok = (pos >= 0);
            if (kind == KIND_REMOVE && pos >= 0) run_list.delete(pos);
         end
         KIND_POP: begin
            if (run_list.size() > 0) begin
               e = run_list.pop_front();
               r.ok = 1'b1;
               r.station = e.station;
               r.minutes = e.minutes;
               n_pops++;
            end else begin
               empty_hits++;
            end
         end
         default: ;
      endcase
      r.entry_count = 5'(run_list.size());
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      err_count++;
      $display("MISMATCH response %0d: %s got 0x%0h, expected 0x%0h",
               n_rsp, field, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 0);
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.ok) report_mismatch("ok", rsp_tuser, want.ok);
            if (rsp_tdata[7:0] !== want.station)
               report_mismatch("out_station", rsp_tdata[7:0], want.station);
            if (rsp_tdata[15:8] !== want.minutes)
               report_mismatch("out_minutes", rsp_tdata[15:8], want.minutes);
            if (rsp_tdata[20:16] !== want.entry_count)
               report_mismatch("entry_count", rsp_tdata[20:16], want.entry_count);
            if (rsp_tdata[23:21] !== 3'b000)
               report_mismatch("tdata padding", rsp_tdata[23:21], 0);
         end
         n_rsp++;
      end
   end

   task automatic send_req(input logic [2:0] kind, input logic [7:0] st, input logic [7:0] mn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {mn, st};
      do @(posedge clock); while (!req_tready);
      due_results.push_back(apply_list_op(kind, st, mn));
      n_req++;
   endtask

   task automatic test_empty_list();
      send_req(KIND_POP, 8'h00, 8'h00);
      send_req(KIND_REMOVE, 8'h00, 8'hFF);
      send_req(KIND_QUERY, 8'hFF, 8'h00);
   endtask

   task automatic test_basic_ops();
      send_req(KIND_APPEND, 8'h00, 8'h00);
      send_req(KIND_PUSH, 8'hFF, 8'hFF);
      send_req(KIND_APPEND, 8'hAA, 8'h55);
      send_req(KIND_APPEND, 8'h55, 8'hAA);
      send_req(KIND_QUERY, 8'hAA, 8'h00);
      send_req(KIND_QUERY, 8'h12, 8'h00);
      send_req(KIND_REMOVE, 8'hAA, 8'h00);
      send_req(KIND_POP, 8'h00, 8'h00);
   endtask

   task automatic test_full_list();
      while (run_list.size() < LIST_DEPTH - 1)
         send_req(KIND_APPEND, 8'(run_list.size()), 8'($urandom));
      send_req(KIND_APPEND, 8'h55, 8'h3C);   // duplicate station
      send_req(KIND_APPEND, 8'h77, 8'h77);
      send_req(KIND_PUSH, 8'h88, 8'h88);
      send_req(KIND_QUERY, 8'h0F, 8'h00);
      send_req(KIND_REMOVE, 8'h55, 8'h00);   // on a full list, first match only
      send_req(KIND_PUSH, 8'hFF, 8'h01);
      send_req(KIND_POP, 8'h00, 8'h00);
      send_req(KIND_REMOVE, run_list[run_list.size() - 1].station, 8'h00);
   endtask

   task automatic test_unused_kinds();
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
         send_req(3'(k), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_off_req = 1'b1;
      for (int i = 0; i < 24; i++)
         send_req($urandom_range(1) ? KIND_APPEND : KIND_QUERY, 8'($urandom), 8'($urandom));
   endtask

   task automatic run_traffic_phase(input int n_items, input int snd_pct, input int rcv_pct);
      int         tilt;
      int         r;
      logic [2:0] kind;
      logic [7:0] st;
      logic [7:0] hot_st [8];
      send_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      tilt = 2;
      foreach (hot_st[i]) hot_st[i] = 8'($urandom);
      for (int i = 0; i < n_items; i++) begin
         if (i % 48 == 0) tilt = $urandom_range(2);
         r = $urandom_range(99);
         if (r < kind_cuts[tilt][0]) kind = KIND_APPEND;
         else if (r < kind_cuts[tilt][1]) kind = KIND_PUSH;
         else if (r < kind_cuts[tilt][2]) kind = KIND_REMOVE;
         else if (r < kind_cuts[tilt][3]) kind = KIND_POP;
         else if (r < kind_cuts[tilt][4]) kind = KIND_QUERY;
         else kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
         if ((kind == KIND_REMOVE || kind == KIND_QUERY) && run_list.size() > 0
             && $urandom_range(1))
            st = run_list[$urandom_range(run_list.size() - 1)].station;
         else if ($urandom_range(3) == 0)
            st = 8'($urandom);
         else
            st = hot_st[$urandom_range(7)];
         send_req(kind, st, 8'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(480, 37, 85);
      run_traffic_phase(480, 85, 37);
      run_traffic_phase(490, 0, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 37;
      rcv_idle_pct = 85;
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_unused_kinds();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests, checked %0d responses in %0d cycles",
               n_req, n_rsp, cycle_count);
      $display("Pops %0d, inserts refused on a full list %0d, pops on an empty list %0d",
               n_pops, full_hits, empty_hits);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", err_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/orl_pkg.sv
hw/rtl/orl_store.sv
hw/rtl/orl_ctrl.sv
hw/rtl/ordered_run_list.sv
hw/rtl/orl_checker.sv
dv/tb_top.sv
